>>> hdl/srtv_pkg.sv
// ----------------------------------------------------------------------------
// srtv_pkg
// Shared types, widths, register codes and reset values for the vertex
// scale / rotate / translate pipeline.
// ----------------------------------------------------------------------------
package srtv_pkg;

  // Default coordinate width (signed Q16.16 at 32 bits)
  localparam int COORD_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  // Register field widths
  localparam int Q_W     = 16;   // quaternion part, signed Q2.14
  localparam int SCALE_W = 16;   // axis scale, unsigned Q8.8
  localparam int POS_W   = 32;   // translation, signed Q16.16
  localparam int QPROD_W = 2 * Q_W;

  // Rotation matrix entry: sums of Q2.14 products, 28 fraction bits
  localparam int M_W = 34;

  // Scaled coordinate is cut at this bit for the two partial products
  localparam int SPLIT_W = 24;

  // Fraction bits dropped at the output (52 down to 16)
  localparam int SHIFT_OUT = 36;

  // Reset values
  localparam logic [Q_W-1:0]       ROT_W_RST = 16'h4000;
  localparam logic [3*SCALE_W-1:0] SCALE_RST = 48'h0100_0100_0100;
  localparam logic [QPROD_W-1:0]   WW_RST    = 32'h1000_0000;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROT_W = 3'd0,
    REG_ROT_X = 3'd1,
    REG_ROT_Y = 3'd2,
    REG_ROT_Z = 3'd3,
    REG_SCALE = 3'd4,
    REG_POS_X = 3'd5,
    REG_POS_Y = 3'd6,
    REG_POS_Z = 3'd7
  } cfg_reg_t;

  typedef logic signed [M_W-1:0] coef_t;

endpackage

>>> hdl/srtv_matrix.sv
// ----------------------------------------------------------------------------
// srtv_matrix
// Configuration registers and the rotation matrix built from the quaternion
// in two register stages (component products, then matrix entries).
// ----------------------------------------------------------------------------
module srtv_matrix (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [srtv_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [srtv_pkg::CFG_DATA_W-1:0]        cfg_data,
  output srtv_pkg::coef_t                        mat   [3][3],
  output logic [srtv_pkg::SCALE_W-1:0]           scale [3],
  output logic signed [srtv_pkg::POS_W-1:0]      pos   [3]
);

  localparam int QW = srtv_pkg::Q_W;
  localparam int PW = srtv_pkg::QPROD_W;
  localparam int MW = srtv_pkg::M_W;
  localparam int SW = srtv_pkg::SCALE_W;

  logic signed [QW-1:0] rot_w, rot_x, rot_y, rot_z;
  logic [3*SW-1:0]      scale_xyz;

  logic signed [PW-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [MW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  srtv_pkg::coef_t      mat_next [3][3];

  // Write registers; unused high data bits drop
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_w     <= srtv_pkg::ROT_W_RST;
      rot_x     <= '0;
      rot_y     <= '0;
      rot_z     <= '0;
      scale_xyz <= srtv_pkg::SCALE_RST;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= '0;
    end else if (cfg_we) begin
      unique case (srtv_pkg::cfg_reg_t'(cfg_index))
        srtv_pkg::REG_ROT_W: rot_w     <= cfg_data[QW-1:0];
        srtv_pkg::REG_ROT_X: rot_x     <= cfg_data[QW-1:0];
        srtv_pkg::REG_ROT_Y: rot_y     <= cfg_data[QW-1:0];
        srtv_pkg::REG_ROT_Z: rot_z     <= cfg_data[QW-1:0];
        srtv_pkg::REG_SCALE: scale_xyz <= cfg_data[3*SW-1:0];
        srtv_pkg::REG_POS_X: pos[0]    <= cfg_data[srtv_pkg::POS_W-1:0];
        srtv_pkg::REG_POS_Y: pos[1]    <= cfg_data[srtv_pkg::POS_W-1:0];
        srtv_pkg::REG_POS_Z: pos[2]    <= cfg_data[srtv_pkg::POS_W-1:0];
      endcase
    end
  end

  // Unpack axis scales
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      scale[j] = scale_xyz[SW*j +: SW];
    end
  end

  // Register quaternion component products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ww <= srtv_pkg::WW_RST;
      p_xx <= '0;
      p_yy <= '0;
      p_zz <= '0;
      p_xy <= '0;
      p_xz <= '0;
      p_yz <= '0;
      p_wx <= '0;
      p_wy <= '0;
      p_wz <= '0;
    end else begin
      p_ww <= rot_w * rot_w;
      p_xx <= rot_x * rot_x;
      p_yy <= rot_y * rot_y;
      p_zz <= rot_z * rot_z;
      p_xy <= rot_x * rot_y;
      p_xz <= rot_x * rot_z;
      p_yz <= rot_y * rot_z;
      p_wx <= rot_w * rot_x;
      p_wy <= rot_w * rot_y;
      p_wz <= rot_w * rot_z;
    end
  end

  // Form matrix entries of q*v*conj(q)
  always_comb begin
    e_ww = MW'(p_ww);
    e_xx = MW'(p_xx);
    e_yy = MW'(p_yy);
    e_zz = MW'(p_zz);
    e_xy = MW'(p_xy);
    e_xz = MW'(p_xz);
    e_yz = MW'(p_yz);
    e_wx = MW'(p_wx);
    e_wy = MW'(p_wy);
    e_wz = MW'(p_wz);

    mat_next[0][0] = e_ww + e_xx - e_yy - e_zz;
    mat_next[0][1] = (e_xy - e_wz) <<< 1;
    mat_next[0][2] = (e_xz + e_wy) <<< 1;
    mat_next[1][0] = (e_xy + e_wz) <<< 1;
    mat_next[1][1] = e_ww - e_xx + e_yy - e_zz;
    mat_next[1][2] = (e_yz - e_wx) <<< 1;
    mat_next[2][0] = (e_xz - e_wy) <<< 1;
    mat_next[2][1] = (e_yz + e_wx) <<< 1;
    mat_next[2][2] = e_ww - e_xx - e_yy + e_zz;
  end

  // Hold matrix; reset value is the identity scaled to 28 fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          mat[r][j] <= (r == j) ? MW'(srtv_pkg::WW_RST) : '0;
        end
      end
    end else begin
      mat <= mat_next;
    end
  end

endmodule

>>> hdl/srtv_scale.sv
// ----------------------------------------------------------------------------
// srtv_scale
// Input register stage and per-axis scale multiply; the scaled coordinate
// leaves split into a low unsigned part and a high signed part.
// ----------------------------------------------------------------------------
module srtv_scale #(
  parameter int C = srtv_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_en,
  input  logic signed [C-1:0]                    coord [3],
  input  logic [srtv_pkg::SCALE_W-1:0]           scale [3],
  input  logic                                   dn_en,
  output logic                                   dn_valid,
  output logic [srtv_pkg::SPLIT_W-1:0]           s_lo  [3],
  output logic signed [C+srtv_pkg::SCALE_W-srtv_pkg::SPLIT_W:0] s_hi [3]
);

  localparam int SW = C + srtv_pkg::SCALE_W + 1;
  localparam int LW = srtv_pkg::SPLIT_W;

  logic                 v0, v1;
  logic                 en0, en1;
  logic signed [C-1:0]  coord_q [3];
  logic signed [SW-1:0] prod    [3];

  // Advance a stage when it is empty or the next one moves
  assign en1   = !v1 || dn_en;
  assign en0   = !v0 || en1;
  assign up_en = en0;

  // Capture vertex on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && up_valid) begin
      coord_q <= coord;
    end
  end

  // Scale each axis by its unsigned Q8.8 factor
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= coord_q[j] * $signed({1'b0, scale[j]});
      end
    end
  end

  // Split scaled coordinates
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s_lo[j] = prod[j][LW-1:0];
      s_hi[j] = prod[j][SW-1:LW];
    end
  end

  assign dn_valid = v1;

endmodule

>>> hdl/srtv_rotate.sv
// ----------------------------------------------------------------------------
// srtv_rotate
// Matrix times scaled vector: one stage of partial products (low and high
// halves of each coordinate), one stage summing them along each row.
// ----------------------------------------------------------------------------
module srtv_rotate #(
  parameter int C = srtv_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_en,
  input  srtv_pkg::coef_t                        mat   [3][3],
  input  logic [srtv_pkg::SPLIT_W-1:0]           s_lo  [3],
  input  logic signed [C+srtv_pkg::SCALE_W-srtv_pkg::SPLIT_W:0] s_hi [3],
  input  logic                                   dn_en,
  output logic                                   dn_valid,
  output logic signed [srtv_pkg::M_W+srtv_pkg::SPLIT_W+2:0] lo_sum [3],
  output logic signed [srtv_pkg::M_W+C+srtv_pkg::SCALE_W-srtv_pkg::SPLIT_W+2:0] hi_sum [3]
);

  localparam int HW    = C + srtv_pkg::SCALE_W + 1 - srtv_pkg::SPLIT_W;
  localparam int LO_W  = srtv_pkg::M_W + srtv_pkg::SPLIT_W + 1;
  localparam int HI_W  = srtv_pkg::M_W + HW;
  localparam int LOS_W = LO_W + 2;
  localparam int HIS_W = HI_W + 2;

  logic                   v2, v3;
  logic                   en2, en3;
  logic signed [LO_W-1:0] pp_lo [3][3];
  logic signed [HI_W-1:0] pp_hi [3][3];

  assign en3   = !v3 || dn_en;
  assign en2   = !v2 || en3;
  assign up_en = en2;

  // Partial products, one multiplier per entry and half
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && up_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          pp_lo[r][j] <= mat[r][j] * $signed({1'b0, s_lo[j]});
          pp_hi[r][j] <= mat[r][j] * s_hi[j];
        end
      end
    end
  end

  // Sum along each row, halves kept apart
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int r = 0; r < 3; r++) begin
        lo_sum[r] <= LOS_W'(pp_lo[r][0]) + LOS_W'(pp_lo[r][1]) + LOS_W'(pp_lo[r][2]);
        hi_sum[r] <= HIS_W'(pp_hi[r][0]) + HIS_W'(pp_hi[r][1]) + HIS_W'(pp_hi[r][2]);
      end
    end
  end

  assign dn_valid = v3;

endmodule

>>> hdl/srtv_round.sv
// ----------------------------------------------------------------------------
// srtv_round
// Join the row halves, add translation and rounding offset, then drop the
// fraction bits, saturate and hold the result in the output register.
// ----------------------------------------------------------------------------
module srtv_round #(
  parameter int C = srtv_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_en,
  input  logic signed [srtv_pkg::M_W+srtv_pkg::SPLIT_W+2:0] lo_sum [3],
  input  logic signed [srtv_pkg::M_W+C+srtv_pkg::SCALE_W-srtv_pkg::SPLIT_W+2:0] hi_sum [3],
  input  logic signed [srtv_pkg::POS_W-1:0]      pos   [3],
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [C-1:0]                    res   [3],
  output logic                                   clipped
);

  localparam int SO  = srtv_pkg::SHIFT_OUT;
  localparam int AW  = C + srtv_pkg::M_W + srtv_pkg::SCALE_W + 4;
  localparam int RW  = AW - SO;
  localparam int TW  = RW - C + 1;

  logic                 v4;
  logic                 en4, en5;
  logic signed [AW-1:0] acc      [3];
  logic signed [AW-1:0] acc_next [3];
  logic signed [C-1:0]  sat      [3];
  logic [2:0]           clip_axis;
  logic [RW-1:0]        rsh;
  logic [TW-1:0]        top;

  assign en5   = !out_valid || out_ready;
  assign en4   = !v4 || en5;
  assign up_en = en4;

  // Full sum; translation sits above the half-LSB rounding bit
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_next[r] = (AW'(hi_sum[r]) <<< srtv_pkg::SPLIT_W) + AW'(lo_sum[r])
                  + AW'($signed({pos[r], 1'b1, {(SO-1){1'b0}}}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && up_valid) begin
      acc <= acc_next;
    end
  end

  // Shift out fraction bits and clamp to the coordinate range
  always_comb begin
    rsh = '0;
    top = '0;
    for (int r = 0; r < 3; r++) begin
      rsh = acc[r][AW-1:SO];
      top = rsh[RW-1:C-1];
      if ((&top) || !(|top)) begin
        sat[r]       = rsh[C-1:0];
        clip_axis[r] = 1'b0;
      end else if (rsh[RW-1]) begin
        sat[r]       = {1'b1, {(C-1){1'b0}}};
        clip_axis[r] = 1'b1;
      end else begin
        sat[r]       = {1'b0, {(C-1){1'b1}}};
        clip_axis[r] = 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      res     <= sat;
      clipped <= |clip_axis;
    end
  end

endmodule

>>> hdl/scale_rotate_translate_vertex.sv
// ----------------------------------------------------------------------------
// scale_rotate_translate_vertex
// Quaternion vertex transform: per-axis scale, rotation by q*v*conj(q),
// translation, round to nearest and saturate.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices enter on in_valid/in_ready as three signed Q16.16 coordinates;
//   results leave on out_valid/out_ready, with clipped set when any axis
//   saturated. A transfer happens on each edge with valid and ready high.
//   Six register stages: input, scale multiply, partial products, row sums,
//   full sum, output. One vertex is taken every cycle while the output drains.
//   Each stage holds when it is full and the stage after it holds, so a stall
//   on out_ready passes back combinationally through the full stages; in_ready
//   drops only when all six stages are full. Bubbles collapse while stalled.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data) used
//   while the pipeline is empty; a write applies to vertices transferred from
//   the next cycle on. The rotation matrix follows the quaternion registers
//   via the product and matrix registers, ahead of the first vertex using it.
//   Synchronous reset loads the identity quaternion, unit scales and zero
//   translation, empties the pipeline and holds in_ready low.
// ----------------------------------------------------------------------------
module scale_rotate_translate_vertex #(
  parameter int COORD_BITS = srtv_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [srtv_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [srtv_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_BITS-1:0]           in_x,
  input  logic signed [COORD_BITS-1:0]           in_y,
  input  logic signed [COORD_BITS-1:0]           in_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [COORD_BITS-1:0]           out_x,
  output logic signed [COORD_BITS-1:0]           out_y,
  output logic signed [COORD_BITS-1:0]           out_z,
  output logic                                   clipped
);

  localparam int C     = COORD_BITS;
  localparam int HW    = C + srtv_pkg::SCALE_W + 1 - srtv_pkg::SPLIT_W;
  localparam int LOS_W = srtv_pkg::M_W + srtv_pkg::SPLIT_W + 3;
  localparam int HIS_W = srtv_pkg::M_W + HW + 2;
  localparam logic signed [C-1:0] MAX_V = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] MIN_V = {1'b1, {(C-1){1'b0}}};

  srtv_pkg::coef_t                  mat   [3][3];
  logic [srtv_pkg::SCALE_W-1:0]     scale [3];
  logic signed [srtv_pkg::POS_W-1:0] pos  [3];
  logic signed [C-1:0]              coord [3];
  logic signed [C-1:0]              res   [3];

  logic                             scale_en, scale_valid;
  logic                             rot_en, rot_valid;
  logic                             round_en;
  logic [srtv_pkg::SPLIT_W-1:0]     s_lo  [3];
  logic signed [HW-1:0]             s_hi  [3];
  logic signed [LOS_W-1:0]          lo_sum [3];
  logic signed [HIS_W-1:0]          hi_sum [3];

  assign coord[0] = in_x;
  assign coord[1] = in_y;
  assign coord[2] = in_z;

  // Block transfers while in reset
  assign in_ready = scale_en && !rst;

  srtv_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .scale     (scale),
    .pos       (pos)
  );

  srtv_scale #(.C(C)) u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_en    (scale_en),
    .coord    (coord),
    .scale    (scale),
    .dn_en    (rot_en),
    .dn_valid (scale_valid),
    .s_lo     (s_lo),
    .s_hi     (s_hi)
  );

  srtv_rotate #(.C(C)) u_rotate (
    .clk      (clk),
    .rst      (rst),
    .up_valid (scale_valid),
    .up_en    (rot_en),
    .mat      (mat),
    .s_lo     (s_lo),
    .s_hi     (s_hi),
    .dn_en    (round_en),
    .dn_valid (rot_valid),
    .lo_sum   (lo_sum),
    .hi_sum   (hi_sum)
  );

  srtv_round #(.C(C)) u_round (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (rot_valid),
    .up_en     (round_en),
    .lo_sum    (lo_sum),
    .hi_sum    (hi_sum),
    .pos       (pos),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .clipped   (clipped)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];

  // A clipped result carries at least one coordinate at a bound
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (out_x == MAX_V || out_x == MIN_V || out_y == MAX_V || out_y == MIN_V ||
       out_z == MAX_V || out_z == MIN_V))
    else $error("clipped set with no coordinate at a saturation bound");

  // Input backs up only when the output is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without an output stall");

  // A result that leaves frees room for a vertex on the next edge
  a_drain_room: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (in_ready || $past(in_valid && in_ready) || !out_ready))
    else $error("pipeline did not make room after an output transfer");

endmodule

>>> bench/vertex_xform_checker.sv
// ----------------------------------------------------------------------------
// vertex_xform_checker
// Watches the configuration port and both vertex channels of the scale /
// rotate / translate block. Keeps its own copy of the registers, predicts the
// transformed vertex for every input transfer and compares each output
// transfer, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module vertex_xform_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [srtv_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [srtv_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [srtv_pkg::COORD_BITS_DEF-1:0] in_x,
  input  logic signed [srtv_pkg::COORD_BITS_DEF-1:0] in_y,
  input  logic signed [srtv_pkg::COORD_BITS_DEF-1:0] in_z,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [srtv_pkg::COORD_BITS_DEF-1:0] out_x,
  input  logic signed [srtv_pkg::COORD_BITS_DEF-1:0] out_y,
  input  logic signed [srtv_pkg::COORD_BITS_DEF-1:0] out_z,
  input  logic                                   clipped,
  output int                                     mismatch_count,
  output int                                     in_flight
);

  localparam int CW = srtv_pkg::COORD_BITS_DEF;
  localparam int QW = srtv_pkg::Q_W;
  localparam int SW = srtv_pkg::SCALE_W;
  localparam int PW = srtv_pkg::POS_W;
  localparam int SO = srtv_pkg::SHIFT_OUT;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 clip;
  } xformed_vertex_t;

  // Shadow copy of the block's registers
  logic signed [QW-1:0]   q_w, q_x, q_y, q_z;
  logic [3*SW-1:0]        axis_scale;
  logic signed [PW-1:0]   off_x, off_y, off_z;

  // Transformed vertices predicted but not yet seen at the output
  xformed_vertex_t predicted_vertices [$];

  // One output axis: matrix row times scaled vector plus offset, then round
  // half up from 52 to 16 fraction bits and clamp to the coordinate range.
  function automatic logic signed [CW-1:0] round_clamp(
    input  logic signed [63:0]    m0, m1, m2,
    input  logic signed [63:0]    s0, s1, s2,
    input  logic signed [PW-1:0]  off,
    output bit                    sat
  );
    logic signed [127:0] acc;
    logic signed [127:0] off_w;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    acc    = m0 * s0 + m1 * s1 + m2 * s2;
    off_w  = off;
    off_w  = off_w <<< SO;
    acc    = acc + off_w + (128'sd1 <<< (SO - 1));
    acc    = acc >>> SO;
    hi_lim = (128'sd1 <<< (CW - 1)) - 128'sd1;
    lo_lim = -(128'sd1 <<< (CW - 1));
    sat    = 1'b0;
    if (acc > hi_lim) begin
      acc = hi_lim;
      sat = 1'b1;
    end else if (acc < lo_lim) begin
      acc = lo_lim;
      sat = 1'b1;
    end
    return acc[CW-1:0];
  endfunction

  // Scale per axis, rotate by q*v*conj(q) without normalization, translate
  function automatic xformed_vertex_t transform_vertex(
    input logic signed [CW-1:0] vx, vy, vz
  );
    logic signed [63:0] w, x, y, z;
    logic signed [63:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [63:0] s0, s1, s2;
    xformed_vertex_t r;
    bit sx, sy, sz;
    w  = q_w;
    x  = q_x;
    y  = q_y;
    z  = q_z;
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    wx = w * x;
    wy = w * y;
    wz = w * z;
    s0 = vx * $signed({1'b0, axis_scale[0*SW +: SW]});
    s1 = vy * $signed({1'b0, axis_scale[1*SW +: SW]});
    s2 = vz * $signed({1'b0, axis_scale[2*SW +: SW]});
    r.x = round_clamp(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy),
                      s0, s1, s2, off_x, sx);
    r.y = round_clamp(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx),
                      s0, s1, s2, off_y, sy);
    r.z = round_clamp(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz,
                      s0, s1, s2, off_z, sz);
    r.clip = sx | sy | sz;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [CW-1:0] want_v,
                             input logic signed [CW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Track registers, predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    xformed_vertex_t want;
    if (rst) begin
      q_w        = srtv_pkg::ROT_W_RST;
      q_x        = '0;
      q_y        = '0;
      q_z        = '0;
      axis_scale = srtv_pkg::SCALE_RST;
      off_x      = '0;
      off_y      = '0;
      off_z      = '0;
      predicted_vertices.delete();
    end else begin
      if (cfg_we) begin
        unique case (srtv_pkg::cfg_reg_t'(cfg_index))
          srtv_pkg::REG_ROT_W: q_w = cfg_data[QW-1:0];
          srtv_pkg::REG_ROT_X: q_x = cfg_data[QW-1:0];
          srtv_pkg::REG_ROT_Y: q_y = cfg_data[QW-1:0];
          srtv_pkg::REG_ROT_Z: q_z = cfg_data[QW-1:0];
          srtv_pkg::REG_SCALE: axis_scale = cfg_data[3*SW-1:0];
          srtv_pkg::REG_POS_X: off_x = cfg_data[PW-1:0];
          srtv_pkg::REG_POS_Y: off_y = cfg_data[PW-1:0];
          srtv_pkg::REG_POS_Z: off_z = cfg_data[PW-1:0];
        endcase
      end

      if (in_valid && in_ready)
        predicted_vertices.push_back(transform_vertex(in_x, in_y, in_z));

      if (out_valid && out_ready) begin
        if (predicted_vertices.size() == 0) begin
          $error("result with nothing expected: out_x %0d out_y %0d out_z %0d clipped %0b",
                 out_x, out_y, out_z, clipped);
          mismatch_count++;
        end else begin
          want = predicted_vertices.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
          check_field("clipped", want.clip, clipped);
        end
      end
    end
    in_flight <= predicted_vertices.size();
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the vertex scale / rotate / translate block: a directed set of
// vertices under extreme and special register settings (rounding ties,
// saturation on each axis, zero scale, non-unit quaternions), then random
// vertices under random settings with random source gaps and sink stalls.
// Checking is done by vertex_xform_checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW = srtv_pkg::COORD_BITS_DEF;
  localparam int QW = srtv_pkg::Q_W;
  localparam int SW = srtv_pkg::SCALE_W;
  localparam int PW = srtv_pkg::POS_W;
  localparam int DW = srtv_pkg::CFG_DATA_W;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int BLOCK_VERTICES = 175;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_we    = 1'b0;
  logic [srtv_pkg::CFG_INDEX_W-1:0] cfg_index = srtv_pkg::REG_ROT_W;
  logic [DW-1:0]            cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic signed [CW-1:0]     in_x      = '0;
  logic signed [CW-1:0]     in_y      = '0;
  logic signed [CW-1:0]     in_z      = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CW-1:0]     out_x, out_y, out_z;
  logic                     clipped;
  int                       mismatch_count;
  int                       in_flight;
  int                       gap_pct   = 0;
  int                       stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scale_rotate_translate_vertex #(.COORD_BITS(CW)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .clipped(clipped)
  );

  vertex_xform_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .clipped(clipped),
    .mismatch_count(mismatch_count), .in_flight(in_flight)
  );

  // Stall the output at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one vertex after a random gap and hold it until the transfer
  task automatic send_vertex(input logic signed [CW-1:0] vx, vy, vz);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x     <= vx;
    in_y     <= vy;
    in_z     <= vz;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted vertex has come out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic put_reg(input srtv_pkg::cfg_reg_t idx,
                         input logic [DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all eight registers; junk rides in the bits above each quaternion and offset register
  task automatic load_setting(input logic [QW-1:0] qw, qx, qy, qz,
                              input logic [3*SW-1:0] scl,
                              input logic [PW-1:0] px, py, pz);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    put_reg(srtv_pkg::REG_ROT_W, {junk[DW-1:QW], qw});
    put_reg(srtv_pkg::REG_ROT_X, {junk[DW-1:QW], qx});
    put_reg(srtv_pkg::REG_ROT_Y, {junk[DW-1:QW], qy});
    put_reg(srtv_pkg::REG_ROT_Z, {junk[DW-1:QW], qz});
    put_reg(srtv_pkg::REG_SCALE, scl);
    put_reg(srtv_pkg::REG_POS_X, {junk[DW-1:PW], px});
    put_reg(srtv_pkg::REG_POS_Y, {junk[DW-1:PW], py});
    put_reg(srtv_pkg::REG_POS_Z, {junk[DW-1:PW], pz});
    cfg_we <= 1'b0;
  endtask

  // Mix near-unit and arbitrary quaternions, scales and offsets
  task automatic load_random_setting();
    logic [QW-1:0]   q [4];
    logic [3*SW-1:0] scl;
    logic [PW-1:0]   p [3];
    foreach (q[i])
      q[i] = $urandom_range(1) ? QW'($urandom) : QW'($urandom_range(0, 32768) - 16384);
    for (int a = 0; a < 3; a++)
      scl[a*SW +: SW] = $urandom_range(1) ? SW'($urandom)
                                          : SW'($urandom_range(64, 512));
    foreach (p[i])
      p[i] = $urandom_range(1) ? PW'($urandom)
                               : PW'($urandom_range(0, 1 << 23) - (1 << 22));
    load_setting(q[0], q[1], q[2], q[3], scl, p[0], p[1], p[2]);
  endtask

  // Coordinates: full range, moderate, small, and the corner values
  function automatic logic signed [CW-1:0] rand_coord();
    unique case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 1 << 21) - (1 << 20));
      2: return CW'($urandom_range(0, 1 << 17) - (1 << 16));
      default:
        unique case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
    endcase
  endfunction

  // Run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int gap_plan [3];
    int stall_plan [3];
    gap_plan   = '{38, 76, 0};
    stall_plan = '{76, 38, 0};
    gap_pct    = gap_plan[0];
    stall_pct <= stall_plan[0];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: identity transform
    send_vertex('0, '0, '0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh1234_5678);
    send_vertex(-1, 1, COORD_MAX);
    drain_pipeline();

    // Half scale: odd coordinates land exactly on rounding ties
    load_setting(srtv_pkg::ROT_W_RST, '0, '0, '0, 48'h0080_0080_0080, '0, '0, '0);
    send_vertex(1, -1, 3);
    send_vertex(-3, 5, -7);
    send_vertex(COORD_MAX, COORD_MIN, 2);
    drain_pipeline();

    // Offsets at the rails: saturate the x and y axes one at a time
    load_setting(srtv_pkg::ROT_W_RST, '0, '0, '0, srtv_pkg::SCALE_RST,
                 COORD_MAX, COORD_MIN, COORD_MAX);
    send_vertex('0, '0, '0);
    send_vertex(1, '0, '0);
    send_vertex('0, -1, '0);
    send_vertex('0, '0, -1);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN);
    drain_pipeline();

    // Most negative quaternion, full scales, top offsets
    load_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, '1,
                 COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(COORD_MAX, COORD_MIN, '0);
    drain_pipeline();

    // Zero scale: output is the offset regardless of rotation
    load_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0,
                 COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(COORD_MAX, COORD_MIN, 12345);
    send_vertex(-1, -1, -1);
    drain_pipeline();

    // Quarter turn about z
    load_setting(16'd11585, '0, '0, 16'd11585, srtv_pkg::SCALE_RST, '0, '0, '0);
    send_vertex(32'sh0001_0000, '0, '0);
    send_vertex('0, 32'sh0001_0000, 32'sh0001_0000);
    send_vertex(32'sh0001_8000, -32'sh0003_0000, 7);
    drain_pipeline();

    // Random vertices under random settings, idling pattern per phase
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct    = gap_plan[ph];
      stall_pct <= stall_plan[ph];
      repeat (2) begin
        load_random_setting();
        repeat (BLOCK_VERTICES) send_vertex(rand_coord(), rand_coord(), rand_coord());
        drain_pipeline();
      end
    end

    // Let any stray output show up
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && in_flight == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
